>>> rtl/lse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types, constants and dot-code functions of the line stage encoder.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int MAX_LINE_BYTES = 64;
  localparam int MAX_SCAN_BYTES = 64;
  localparam int STORE_AW       = $clog2(MAX_LINE_BYTES);

  localparam logic [7:0] ODD_MASK  = 8'haa;
  localparam logic [7:0] EVEN_MASK = 8'h55;
  localparam logic [7:0] SCAN_ON   = 8'hc0;

  localparam logic [6:0] LINE_BYTES_RST   = 7'd33;
  localparam logic [6:0] SCAN_BYTES_RST   = 7'd44;
  localparam logic [1:0] FILLER_BYTES_RST = 2'd1;

  typedef enum logic [1:0] {
    REG_LINE_BYTES   = 2'd0,
    REG_SCAN_BYTES   = 2'd1,
    REG_FILLER_BYTES = 2'd2
  } reg_index_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PULL = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    STG_COMPENSATE = 3'd0,
    STG_WHITE      = 3'd1,
    STG_INVERSE    = 3'd2,
    STG_NORMAL     = 3'd3,
    STG_POWER_OFF  = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    SEG_ODD    = 2'd0,
    SEG_SCAN   = 2'd1,
    SEG_EVEN   = 2'd2,
    SEG_FILLER = 2'd3
  } segment_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

  function automatic logic [7:0] pair_reverse(input logic [7:0] v);
    return {v[1:0], v[3:2], v[5:4], v[7:6]};
  endfunction

  function automatic logic [7:0] odd_code(input logic [7:0] raw, input logic [2:0] stg);
    logic [7:0] d;
    d = raw & ODD_MASK;
    unique case (stg)
      STG_COMPENSATE: return ~(d >> 1);
      STG_WHITE:      return d ^ ODD_MASK;
      STG_INVERSE:    return ~d;
      STG_NORMAL:     return (d >> 1) | ODD_MASK;
      default:        return EVEN_MASK;
    endcase
  endfunction

  function automatic logic [7:0] even_code(input logic [7:0] raw, input logic [2:0] stg);
    logic [7:0] d;
    d = raw & EVEN_MASK;
    unique case (stg)
      STG_COMPENSATE: return pair_reverse(~d);
      STG_WHITE:      return pair_reverse((d ^ EVEN_MASK) << 1);
      STG_INVERSE:    return pair_reverse((d + EVEN_MASK) ^ ODD_MASK);
      STG_NORMAL:     return pair_reverse(d | ODD_MASK);
      default:        return EVEN_MASK;
    endcase
  endfunction

endpackage

>>> rtl/epaper_line_stage_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epaper_line_stage_encoder_unit
// Buffers one frame line and emits it as a staged two-bit panel line.
// ----------------------------------------------------------------------------
// A load word writes one frame byte into the line RAM while the store is not
// full; a pull word reads one line RAM entry into the registered read port of
// the RAM, and its output byte is registered in the fetch state once the output
// register is free, so no new input word is taken until then. While the output
// register still holds an unaccepted word, a following pull waits in fetch and
// holds off further input words; a pending output word does not block loads.
// Configuration writes are accepted every cycle outside reset.
module epaper_line_stage_encoder_unit
  import lse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] frame_byte,
  input  logic [2:0] stage,
  input  logic [7:0] line_index,
  input  logic       blank_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_out
);

  logic [6:0] line_bytes;
  logic [6:0] scan_bytes;
  logic [1:0] filler_bytes;
  logic [6:0] load_count;
  logic [7:0] emit_position;
  logic [2:0] held_stage;
  logic [7:0] held_line;
  logic       held_blank;

  state_t     state, state_next;
  segment_t   seg, seg_next;
  logic [7:0] scan_val, scan_val_next;
  logic       last_pend, last_pend_next;

  logic [6:0] lb, sb;
  logic [8:0] end_odd, end_scan, end_even, total;
  logic [8:0] p_ext, p_inc;
  logic [8:0] odd_idx, even_idx;
  logic [6:0] scan_i;
  logic [STORE_AW-1:0] raddr;
  logic       last_now;
  logic       in_fire, cfg_fire, load_fire, pull_fire, out_load;
  logic       store_we;
  logic [7:0] rdata;
  logic [7:0] result;

  assign cfg_ready = !rst;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !rst && (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (command == CMD_LOAD);
  assign pull_fire = in_fire && (command == CMD_PULL);
  assign store_we  = load_fire && !load_count[6];

  assign lb = (line_bytes > 7'(MAX_LINE_BYTES)) ? 7'(MAX_LINE_BYTES) : line_bytes;
  assign sb = (scan_bytes > 7'(MAX_SCAN_BYTES)) ? 7'(MAX_SCAN_BYTES) : scan_bytes;

  assign end_odd  = {2'b00, lb};
  assign end_scan = end_odd + {2'b00, sb};
  assign end_even = end_scan + {2'b00, lb};
  assign total    = end_even + {7'd0, filler_bytes};
  assign p_ext    = {1'b0, emit_position};
  assign p_inc    = p_ext + 9'd1;
  assign last_now = (total == 9'd0) || (p_inc >= total);

  assign odd_idx  = end_odd - 9'd1 - p_ext;
  assign even_idx = p_ext - end_scan;
  assign scan_i   = 7'(p_ext - end_odd);

  always_comb begin
    priority if (p_ext < end_odd) begin
      seg_next = SEG_ODD;
      raddr    = odd_idx[STORE_AW-1:0];
    end else if (p_ext < end_scan) begin
      seg_next = SEG_SCAN;
      raddr    = odd_idx[STORE_AW-1:0];
    end else if (p_ext < end_even) begin
      seg_next = SEG_EVEN;
      raddr    = even_idx[STORE_AW-1:0];
    end else begin
      seg_next = SEG_FILLER;
      raddr    = even_idx[STORE_AW-1:0];
    end
  end

  always_comb begin
    scan_val_next = 8'd0;
    if (!held_blank && (scan_i == {1'b0, held_line[7:2]})) begin
      scan_val_next = SCAN_ON >> {held_line[1:0], 1'b0};
    end
  end

  assign last_pend_next = last_now;

  lse_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (load_count[STORE_AW-1:0]),
    .wdata (frame_byte),
    .re    (pull_fire),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (seg)
      SEG_ODD:    result = odd_code(held_blank ? 8'd0 : rdata, held_stage);
      SEG_SCAN:   result = scan_val;
      SEG_EVEN:   result = even_code(held_blank ? 8'd0 : rdata, held_stage);
      SEG_FILLER: result = 8'd0;
      default:    result = 8'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (pull_fire) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pull_fire) begin
      seg       <= seg_next;
      scan_val  <= scan_val_next;
      last_pend <= last_pend_next;
    end
    if (out_load) begin
      out_byte <= result;
      last_out <= last_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes   <= LINE_BYTES_RST;
      scan_bytes   <= SCAN_BYTES_RST;
      filler_bytes <= FILLER_BYTES_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_LINE_BYTES:   line_bytes   <= cfg_data;
        REG_SCAN_BYTES:   scan_bytes   <= cfg_data;
        REG_FILLER_BYTES: filler_bytes <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= 7'd0;
      emit_position <= 8'd0;
      held_stage    <= STG_COMPENSATE;
      held_line     <= 8'd0;
      held_blank    <= 1'b0;
    end else if (load_fire) begin
      if (!load_count[6]) begin
        load_count <= load_count + 7'd1;
      end
      held_stage    <= stage;
      held_line     <= line_index;
      held_blank    <= blank_line;
      emit_position <= 8'd0;
    end else if (pull_fire) begin
      if (last_now) begin
        emit_position <= 8'd0;
        load_count    <= 7'd0;
      end else begin
        emit_position <= p_inc[7:0];
      end
    end
  end

endmodule

>>> rtl/lse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> test/tb_epaper_line_stage_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epaper_line_stage_encoder_unit
// Loads frame lines and pulls the staged panel line back out, word by word,
// under random sender bursts and receiver stalls. A built-in line encoder
// predicts every pulled byte and its last flag, and each accepted output
// word is compared with the oldest prediction. The line register settings
// change between phases, including zero, maximum and oversized values.
// ----------------------------------------------------------------------------
module tb_epaper_line_stage_encoder_unit;
  import lse_pkg::*;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam logic [2:0] STG_RESERVED = 3'd7;
  localparam int RANDOM_WORDS = 1030;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 50;

  typedef struct {
    command_t   cmd;
    logic [7:0] fbyte;
    logic [2:0] stg;
    logic [7:0] line;
    logic       blank;
  } line_word_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } panel_byte_t;

  typedef struct {
    logic [1:0] idx;
    logic [6:0] data;
  } reg_write_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = 1'b0;
  logic [7:0] frame_byte = '0;
  logic [2:0] stage = '0;
  logic [7:0] line_index = '0;
  logic       blank_line = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_out;

  epaper_line_stage_encoder_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .frame_byte (frame_byte),
    .stage      (stage),
    .line_index (line_index),
    .blank_line (blank_line),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_out   (last_out)
  );

  always #4 clk = ~clk;

  line_word_t  word_queue[$];
  reg_write_t  reg_writes[$];
  panel_byte_t panel_bytes_due[$];
  int          mismatches = 0;
  int          words_queued = 0;

  // line encoder state
  logic [6:0] enc_line_bytes;
  logic [6:0] enc_scan_bytes;
  logic [1:0] enc_filler_bytes;
  logic [7:0] line_mem [MAX_LINE_BYTES];
  int         fill_count;
  int         emit_pos;
  logic [2:0] lat_stage;
  logic [7:0] lat_line;
  logic       lat_blank;

  // register values as last programmed, used to shape the stimulus
  int cur_line = int'(LINE_BYTES_RST);
  int cur_scan = int'(SCAN_BYTES_RST);
  int cur_filler = int'(FILLER_BYTES_RST);

  function automatic int span(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [1:0] dot_pair(logic [2:0] stg, logic dot, logic even_half);
    case (stg)
      STG_COMPENSATE: return {1'b1, ~dot};
      STG_WHITE:      return {~dot, 1'b0};
      STG_INVERSE:    return even_half ? {~dot, ~dot} : {~dot, 1'b1};
      STG_NORMAL:     return {1'b1, dot};
      default:        return 2'b01;
    endcase
  endfunction

  function automatic logic [7:0] odd_dots(logic [7:0] raw);
    logic [7:0] b;
    for (int k = 0; k < 4; k++) b[2*k +: 2] = dot_pair(lat_stage, raw[2*k+1], 1'b0);
    return b;
  endfunction

  // even dots come out with the pair order of the byte mirrored
  function automatic logic [7:0] even_dots(logic [7:0] raw);
    logic [7:0] b;
    for (int k = 0; k < 4; k++) b[2*(3-k) +: 2] = dot_pair(lat_stage, raw[2*k], 1'b1);
    return b;
  endfunction

  function automatic logic [7:0] stored_dots(int idx);
    return lat_blank ? 8'h00 : line_mem[idx];
  endfunction

  function automatic void reset_encoder();
    enc_line_bytes   = LINE_BYTES_RST;
    enc_scan_bytes   = SCAN_BYTES_RST;
    enc_filler_bytes = FILLER_BYTES_RST;
    fill_count = 0;
    emit_pos   = 0;
    lat_stage  = '0;
    lat_line   = '0;
    lat_blank  = 1'b0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [6:0] data);
    case (idx)
      REG_LINE_BYTES:   enc_line_bytes = data;
      REG_SCAN_BYTES:   enc_scan_bytes = data;
      REG_FILLER_BYTES: enc_filler_bytes = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic void take_word(line_word_t w);
    int lb, sb, total, p;
    panel_byte_t r;
    lb = span(int'(enc_line_bytes), MAX_LINE_BYTES);
    sb = span(int'(enc_scan_bytes), MAX_SCAN_BYTES);
    total = 2 * lb + sb + int'(enc_filler_bytes);
    p = emit_pos;
    if (w.cmd == CMD_LOAD) begin
      if (fill_count < MAX_LINE_BYTES) begin
        line_mem[fill_count] = w.fbyte;
        fill_count++;
      end
      lat_stage = w.stg;
      lat_line  = w.line;
      lat_blank = w.blank;
      emit_pos  = 0;
      return;
    end
    r.data = 8'h00;
    if (p < lb) begin
      r.data = odd_dots(stored_dots(lb - 1 - p));
    end else if (p < lb + sb) begin
      if (!lat_blank && (p - lb) == int'(lat_line >> 2))
        r.data = SCAN_ON >> (2 * lat_line[1:0]);
    end else if (p < 2 * lb + sb) begin
      r.data = even_dots(stored_dots(p - lb - sb));
    end
    r.last = (total == 0) || (p + 1 >= total);
    if (r.last) begin
      emit_pos   = 0;
      fill_count = 0;
    end else begin
      emit_pos = p + 1;
    end
    panel_bytes_due.push_back(r);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- drivers
  reg_write_t cfg_head;
  line_word_t word_head;
  int         burst_left = 1;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (reg_writes.size() > 0) begin
        cfg_head = reg_writes.pop_front();
        cfg_index <= cfg_head.idx;
        cfg_data  <= cfg_head.data;
        cfg_valid <= 1'b1;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || word_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        word_head = word_queue.pop_front();
        command    <= word_head.cmd;
        frame_byte <= word_head.fbyte;
        stage      <= word_head.stg;
        line_index <= word_head.line;
        blank_line <= word_head.blank;
        in_valid   <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  rx_mode_t    rx_mode = RX_OPEN;
  logic [15:0] rx_cycle = '0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle[7:0] == 8'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_cycle[2:0] == 3'd0);
      default:   out_ready <= rx_cycle[4];
    endcase
  end

  // ---------------------------------------------------------------- checker
  line_word_t  seen_word;
  panel_byte_t want;

  always @(posedge clk) begin
    if (rst) begin
      reset_encoder();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        seen_word.cmd   = command_t'(command);
        seen_word.fbyte = frame_byte;
        seen_word.stg   = stage;
        seen_word.line  = line_index;
        seen_word.blank = blank_line;
        take_word(seen_word);
      end
      if (out_valid && out_ready) begin
        if (panel_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word byte %02h last %0b", out_byte, last_out));
        end else begin
          want = panel_bytes_due.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (last_out !== want.last)
            report_mismatch($sformatf("last_out %0b, want %0b (byte %02h)",
                                      last_out, want.last, want.data));
        end
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic add_word(command_t cmd, logic [7:0] fb, logic [2:0] stg, logic [7:0] ln,
                          logic blank);
    line_word_t w;
    w.cmd   = cmd;
    w.fbyte = fb;
    w.stg   = stg;
    w.line  = ln;
    w.blank = blank;
    word_queue.push_back(w);
    words_queued++;
  endtask

  task automatic add_loads(int n, logic [2:0] stg, logic [7:0] ln, logic blank);
    repeat (n) add_word(CMD_LOAD, 8'($urandom_range(0, 255)), stg, ln, blank);
  endtask

  task automatic add_pulls(int n);
    repeat (n) add_word(CMD_PULL, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  function automatic int line_total();
    return 2 * span(cur_line, MAX_LINE_BYTES) + span(cur_scan, MAX_SCAN_BYTES) + cur_filler;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (word_queue.size() != 0 || in_valid || panel_bytes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(int lbv, int sbv, int fv, bit stray);
    reg_write_t rw;
    wait_idle();
    rw.idx = REG_LINE_BYTES;   rw.data = 7'(lbv); reg_writes.push_back(rw);
    if (stray) begin
      rw.idx = REG_UNUSED; rw.data = 7'($urandom_range(0, 127)); reg_writes.push_back(rw);
    end
    rw.idx = REG_SCAN_BYTES;   rw.data = 7'(sbv); reg_writes.push_back(rw);
    rw.idx = REG_FILLER_BYTES; rw.data = 7'(fv);  reg_writes.push_back(rw);
    do @(negedge clk); while (reg_writes.size() != 0 || cfg_valid);
    cur_line   = lbv;
    cur_scan   = sbv;
    cur_filler = fv;
  endtask

  task automatic random_line();
    int lb, hi, total, kind;
    logic [2:0] stg;
    logic [7:0] ln;
    logic blank;
    lb = span(cur_line, MAX_LINE_BYTES);
    hi = 4 * span(cur_scan, MAX_SCAN_BYTES) + 3;
    if (hi > 255) hi = 255;
    total = line_total();
    stg   = 3'($urandom_range(0, 7));
    ln    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                          8'($urandom_range(0, hi));
    blank = ($urandom_range(0, 5) == 0);
    kind  = $urandom_range(0, 9);
    if (kind == 8) begin
      repeat ($urandom_range(1, 12))
        add_word(command_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end else begin
      add_loads((kind == 9) ? lb + $urandom_range(1, 4) : lb, stg, ln, blank);
      add_pulls((kind == 7) ? $urandom_range(0, total) : total);
    end
  endtask

  initial begin
    int start, pick, lbv, sbv;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // fill the whole store first, two loads past the end; latched values match reset
    add_loads(MAX_LINE_BYTES + 2, STG_COMPENSATE, 8'd0, 1'b0);
    add_pulls(line_total() + 3);

    program_regs(1, 1, 0, 1'b0);
    add_word(CMD_LOAD, 8'h00, STG_COMPENSATE, 8'd0, 1'b0);   add_pulls(3);
    add_word(CMD_LOAD, 8'hff, STG_WHITE, 8'd1, 1'b0);        add_pulls(3);
    add_word(CMD_LOAD, 8'ha5, STG_INVERSE, 8'd2, 1'b0);      add_pulls(3);
    add_word(CMD_LOAD, 8'h5a, STG_NORMAL, 8'd3, 1'b0);       add_pulls(3);
    add_word(CMD_LOAD, 8'hff, STG_POWER_OFF, 8'd4, 1'b0);    add_pulls(3);
    add_word(CMD_LOAD, 8'hc3, STG_RESERVED, 8'd255, 1'b1);   add_pulls(3);

    // empty sequence
    program_regs(0, 0, 0, 1'b0);
    add_pulls(2);

    // oversized registers clamp to the store size
    program_regs(127, 127, 3, 1'b1);
    add_loads(MAX_LINE_BYTES, STG_NORMAL, 8'd255, 1'b0);
    add_pulls(line_total());

    start = words_queued;
    while (words_queued - start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 14);
      if (pick == 0) begin
        lbv = $urandom_range(0, 127);
        sbv = $urandom_range(0, 127);
      end else if (pick <= 2) begin
        lbv = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        sbv = (lbv != 0) ? 0 : $urandom_range(0, 6);
      end else begin
        lbv = $urandom_range(1, 6);
        sbv = $urandom_range(1, 6);
      end
      program_regs(lbv, sbv, $urandom_range(0, 3), $urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 6)) random_line();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_epaper_line_stage_encoder_unit: done, clean");
    end else begin
      $display("tb_epaper_line_stage_encoder_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TIMEOUT: %0d output words still due", panel_bytes_due.size());
    $display("tb_epaper_line_stage_encoder_unit: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/lse_pkg.sv
rtl/lse_ram.sv
rtl/epaper_line_stage_encoder_unit.sv
test/tb_epaper_line_stage_encoder_unit.sv
